// ===== rtl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg
// shared types, constants and register map of the box filter downsampler
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

  // parameter defaults
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_FACTOR_DEF = 8;
  localparam int unsigned CHANNELS_DEF   = 4;

  // fixed field widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned FACTOR_W  = 4;
  localparam int unsigned ROW_W     = 12;

  localparam int unsigned HEIGHT_LIMIT = 4096;

  // apb register port
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BLOCK_FACTOR = 2'd2;

  // register reset values
  localparam logic [DIM_W-1:0]    IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]    IMAGE_HEIGHT_RST = 13'd480;
  localparam logic [FACTOR_W-1:0] BLOCK_FACTOR_RST = 4'd2;

  typedef struct packed {
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
    logic [PIX_W-1:0] in_alpha;
  } bfd_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_alpha;
    logic             end_of_line;
    logic             end_of_frame;
  } bfd_out_t;

  // configuration after clamping to legal ranges
  typedef struct packed {
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [FACTOR_W-1:0] factor;
  } bfd_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_HOLD
  } bfd_state_e;

  typedef struct packed {
    logic accept;
    logic accumulate;
    logic div_step;
    logic load_out;
  } bfd_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_last;
    logic out_free;
  } bfd_status_t;

endpackage

`default_nettype wire

// ===== rtl/box_filter_downsampler_core.sv =====
// ----------------------------------------------------------------------------
// box_filter_downsampler_core
// per-channel box average of factor x factor pixel blocks in a raster stream
// ----------------------------------------------------------------------------
// latency: a pixel that closes no block frees the input after its accumulate
//   state; a block-closing pixel has its result in the output register after
//   the accumulate state, the divider steps over the 14-bit sum and the hold
//   state, which waits for a free output register; a new pixel is taken only
//   when the last is through the column sum read-modify-write and divider
// reset: position counters cleared, registers at 640 x 480 with factor 2;
//   the column sum memory is not cleared, a block's first pixel overwrites it
`default_nettype none

module box_filter_downsampler_core #(
  parameter int unsigned MAX_WIDTH  = bfd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_FACTOR = bfd_pkg::MAX_FACTOR_DEF,
  parameter int unsigned CHANNELS   = bfd_pkg::CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // pixel input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bfd_pkg::bfd_in_t               in_data_i,
  // averaged pixel output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bfd_pkg::bfd_out_t              out_data_o,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bfd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bfd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bfd_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bfd_pkg::*;

  bfd_cfg_t    cfg;
  bfd_cmd_t    cmd;
  bfd_status_t status;

  // width, height and factor registers, clamped before use
  bfd_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // sequencer: input is taken only in idle, one pixel in flight at a time
  bfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // counters, column sums, dividers; the output register lets a result
  // wait for the consumer while further pixels come in
  bfd_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR),
    .CHANNELS   (CHANNELS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // one pixel in flight: input closes right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken twice in a row");

  // a result is only loaded when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten");

  // a new result appears only after a load command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load_out))
    else $error("output valid without load");

  // frame end is always also a line end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.end_of_frame) |-> out_data_o.end_of_line)
    else $error("frame end without line end");

endmodule

`default_nettype wire

// ===== rtl/bfd_regs.sv =====
// ----------------------------------------------------------------------------
// bfd_regs
// apb configuration registers with range clamping
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_regs #(
  parameter int unsigned MAX_WIDTH  = bfd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_FACTOR = bfd_pkg::MAX_FACTOR_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [bfd_pkg::APB_ADDR_W-1:0]    paddr_i,
  input  logic [bfd_pkg::APB_DATA_W-1:0]    pwdata_i,
  output logic [bfd_pkg::APB_DATA_W-1:0]    prdata_o,
  output logic                              pready_o,
  output bfd_pkg::bfd_cfg_t                 cfg_o
);
  import bfd_pkg::*;

  localparam int unsigned DimW1    = DIM_W + 1;
  localparam int unsigned FactorW1 = FACTOR_W + 1;
  localparam logic [DIM_W:0]    WidthLim  = DimW1'(MAX_WIDTH);
  localparam logic [DIM_W:0]    HeightLim = DimW1'(HEIGHT_LIMIT);
  localparam logic [FACTOR_W:0] FactorLim = FactorW1'(MAX_FACTOR);

  logic [DIM_W-1:0]    width_q, height_q;
  logic [FACTOR_W-1:0] factor_q;
  logic [1:0]          idx;
  logic                wr_en;

  assign pready_o = 1'b1;
  assign idx      = paddr_i[APB_ADDR_W-1:2];
  assign wr_en    = psel_i & penable_i & pwrite_i & pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMAGE_WIDTH_RST;
      height_q <= IMAGE_HEIGHT_RST;
      factor_q <= BLOCK_FACTOR_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_IMAGE_WIDTH:  width_q  <= pwdata_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata_i[DIM_W-1:0];
        REG_BLOCK_FACTOR: factor_q <= pwdata_i[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:  prdata_o = APB_DATA_W'(width_q);
      REG_IMAGE_HEIGHT: prdata_o = APB_DATA_W'(height_q);
      REG_BLOCK_FACTOR: prdata_o = APB_DATA_W'(factor_q);
      default:          prdata_o = '0;
    endcase
  end

  // zero counts as one, large values saturate
  always_comb begin
    if (width_q == '0) begin
      cfg_o.width = DIM_W'(1);
    end else if ({1'b0, width_q} > WidthLim) begin
      cfg_o.width = WidthLim[DIM_W-1:0];
    end else begin
      cfg_o.width = width_q;
    end
    if (height_q == '0) begin
      cfg_o.height = DIM_W'(1);
    end else if ({1'b0, height_q} > HeightLim) begin
      cfg_o.height = HeightLim[DIM_W-1:0];
    end else begin
      cfg_o.height = height_q;
    end
    if (factor_q == '0) begin
      cfg_o.factor = FACTOR_W'(1);
    end else if ({1'b0, factor_q} > FactorLim) begin
      cfg_o.factor = FactorLim[FACTOR_W-1:0];
    end else begin
      cfg_o.factor = factor_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfd_ctrl
// sequencer: accept, accumulate, divide, hand result to output register
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bfd_pkg::bfd_status_t status_i,
  output bfd_pkg::bfd_cmd_t    cmd_o
);
  import bfd_pkg::*;

  bfd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.accumulate = 1'b1;
        state_d = status_i.emit ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bfd_dpath.sv =====
// ----------------------------------------------------------------------------
// bfd_dpath
// position counters, column sum memory, bit-serial dividers, output register
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_dpath #(
  parameter int unsigned MAX_WIDTH  = bfd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_FACTOR = bfd_pkg::MAX_FACTOR_DEF,
  parameter int unsigned CHANNELS   = bfd_pkg::CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bfd_pkg::bfd_cfg_t    cfg_i,
  input  bfd_pkg::bfd_in_t     in_data_i,
  input  bfd_pkg::bfd_cmd_t    cmd_i,
  output bfd_pkg::bfd_status_t status_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output bfd_pkg::bfd_out_t    out_data_o
);
  import bfd_pkg::*;

  localparam int unsigned AddrW    = $clog2(MAX_WIDTH);
  localparam int unsigned IbW      = $clog2(MAX_FACTOR);
  localparam int unsigned SideW    = $clog2(MAX_FACTOR + 1);
  localparam int unsigned CntW     = 2 * SideW;
  localparam int unsigned PixMax   = (1 << PIX_W) - 1;
  localparam int unsigned SumLimit = MAX_FACTOR * MAX_FACTOR * PixMax;
  localparam int unsigned SumW     = $clog2(SumLimit + 1);
  localparam int unsigned SumW1    = SumW + 1;
  localparam int unsigned WordW    = CHANNELS * SumW;
  localparam int unsigned StepW    = $clog2(SumW);
  localparam int unsigned PosW     = ((AddrW > DIM_W) ? AddrW : DIM_W) + 1;
  localparam int unsigned RowCmpW  = ((ROW_W > DIM_W) ? ROW_W : DIM_W) + 1;
  localparam int unsigned FPosW    = ((IbW > FACTOR_W) ? IbW : FACTOR_W) + 1;

  // position counters
  logic [AddrW-1:0] pc_q, pc_d, oc_q, oc_d;
  logic [ROW_W-1:0] pr_q, pr_d;
  logic [IbW-1:0]   cib_q, cib_d, rib_q, rib_d;

  logic col_last, row_last, cib_full, rib_full, bcol_last, brow_last, fresh;
  logic [SideW-1:0] cols, rows;
  logic [CntW-1:0]  cnt;

  // per transaction registers
  logic [NUM_LANES-1:0][PIX_W-1:0] px_all;
  logic [CHANNELS-1:0][PIX_W-1:0]  px_q;
  logic                            fresh_q, emit_q, col_last_q, row_last_q;
  logic [CntW-1:0]                 cnt_q;
  logic [AddrW-1:0]                addr_q;

  logic [WordW-1:0] col_sums_q [MAX_WIDTH];
  logic [WordW-1:0] rd_q;
  logic [WordW-1:0] wr_word;
  logic [CHANNELS-1:0][SumW-1:0] sum;

  // divider lanes
  logic [CHANNELS-1:0][CntW-1:0] rem_q, rem_d;
  logic [CHANNELS-1:0][SumW-1:0] quo_q, quo_d;
  logic [StepW-1:0]              step_q;

  logic [NUM_LANES-1:0][PIX_W-1:0] avg;
  logic                            out_valid_q;
  bfd_out_t                        out_q;

  assign px_all = {in_data_i.in_alpha, in_data_i.in_blue,
                   in_data_i.in_green, in_data_i.in_red};

  always_comb begin
    col_last  = PosW'(pc_q) >= (PosW'(cfg_i.width) - PosW'(1));
    row_last  = RowCmpW'(pr_q) >= (RowCmpW'(cfg_i.height) - RowCmpW'(1));
    cib_full  = FPosW'(cib_q) >= (FPosW'(cfg_i.factor) - FPosW'(1));
    rib_full  = FPosW'(rib_q) >= (FPosW'(cfg_i.factor) - FPosW'(1));
    bcol_last = col_last | cib_full;
    brow_last = row_last | rib_full;
    fresh     = (cib_q == '0) && (rib_q == '0);
    cols      = cib_full ? SideW'(cfg_i.factor) : SideW'(cib_q) + SideW'(1);
    rows      = rib_full ? SideW'(cfg_i.factor) : SideW'(rib_q) + SideW'(1);
    cnt       = CntW'(cols) * CntW'(rows);
  end

  // counter advance, same order of tests as the raster walk
  always_comb begin
    pc_d  = pc_q;
    pr_d  = pr_q;
    cib_d = cib_q;
    rib_d = rib_q;
    oc_d  = oc_q;
    if (col_last) begin
      pc_d  = '0;
      cib_d = '0;
      oc_d  = '0;
      if (row_last) begin
        pr_d  = '0;
        rib_d = '0;
      end else begin
        pr_d  = pr_q + ROW_W'(1);
        rib_d = brow_last ? '0 : rib_q + IbW'(1);
      end
    end else begin
      pc_d = pc_q + AddrW'(1);
      if (bcol_last) begin
        cib_d = '0;
        oc_d  = (oc_q == AddrW'(MAX_WIDTH - 1)) ? '0 : oc_q + AddrW'(1);
      end else begin
        cib_d = cib_q + IbW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      pr_q   <= '0;
      cib_q  <= '0;
      rib_q  <= '0;
      oc_q   <= '0;
      emit_q <= 1'b0;
    end else if (cmd_i.accept) begin
      pc_q   <= pc_d;
      pr_q   <= pr_d;
      cib_q  <= cib_d;
      rib_q  <= rib_d;
      oc_q   <= oc_d;
      emit_q <= bcol_last & brow_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int c = 0; c < CHANNELS; c++) begin
        px_q[c] <= px_all[c];
      end
      fresh_q    <= fresh;
      col_last_q <= col_last;
      row_last_q <= row_last;
      cnt_q      <= cnt;
      addr_q     <= oc_q;
    end
  end

  // column sum memory: read at accept, written back in the accumulate cycle after it
  always_ff @(posedge clk_i) begin
    if (cmd_i.accumulate) begin
      col_sums_q[addr_q] <= wr_word;
    end
    if (cmd_i.accept) begin
      rd_q <= col_sums_q[oc_q];
    end
  end

  // block start overwrites, otherwise add with saturation
  always_comb begin
    logic [SumW:0] acc;
    for (int c = 0; c < CHANNELS; c++) begin
      acc = fresh_q ? SumW1'(px_q[c])
                    : SumW1'(rd_q[c*SumW +: SumW]) + SumW1'(px_q[c]);
      sum[c] = (acc > SumW1'(SumLimit)) ? SumW'(SumLimit) : acc[SumW-1:0];
      wr_word[c*SumW +: SumW] = sum[c];
    end
  end

  // restoring division, one quotient bit per step on every lane
  always_comb begin
    logic [CntW:0] trial;
    logic          ge;
    for (int c = 0; c < CHANNELS; c++) begin
      trial    = {rem_q[c], quo_q[c][SumW-1]};
      ge       = trial >= {1'b0, cnt_q};
      rem_d[c] = ge ? CntW'(trial - {1'b0, cnt_q}) : trial[CntW-1:0];
      quo_d[c] = {quo_q[c][SumW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accumulate && emit_q) begin
      rem_q  <= '0;
      quo_q  <= sum;
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      step_q <= step_q + StepW'(1);
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_avg
    if (g < CHANNELS) begin : g_used
      assign avg[g] = (quo_q[g] > SumW'(PixMax)) ? PIX_W'(PixMax) : quo_q[g][PIX_W-1:0];
    end else begin : g_unused
      assign avg[g] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.out_red      <= avg[0];
      out_q.out_green    <= avg[1];
      out_q.out_blue     <= avg[2];
      out_q.out_alpha    <= avg[3];
      out_q.end_of_line  <= col_last_q;
      out_q.end_of_frame <= col_last_q & row_last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.emit     = emit_q;
  assign status_o.div_last = (step_q == StepW'(SumW - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire
